FILE: design/dtw_pkg.sv
`default_nettype none

package dtw_pkg;

    localparam int TimerTwoWidth = 32;
    localparam int TimerOneWidth = 4;

    typedef enum logic [2:0] {
        REQ_T1_TICK  = 3'd0,
        REQ_T2_TICK  = 3'd1,
        REQ_RD_T1    = 3'd2,
        REQ_RD_T2    = 3'd3,
        REQ_WR_T1    = 3'd4,
        REQ_WR_T2    = 3'd5,
        REQ_CTL_T1   = 3'd6,
        REQ_CTL_T2   = 3'd7
    } req_type_t;

    localparam logic [TimerTwoWidth-1:0] ALL_ONES = {TimerTwoWidth{1'b1}};

    typedef struct packed {
        logic [2:0]               req_type;
        logic [TimerTwoWidth-1:0] write_data;
        logic                     ctl_wake;
        logic                     ctl_int;
        logic                     ctl_run;
        logic                     cpu_shutdown;
        logic                     interrupts_enabled;
    } in_item_t;

    typedef struct packed {
        logic [TimerTwoWidth-1:0] read_data;
        logic                     t1_request;
        logic                     t2_request;
        logic                     t1_wake_state;
        logic                     t2_wake_state;
        logic                     interrupt_pulse;
        logic                     wake_pulse;
    } out_item_t;

endpackage

`default_nettype wire

FILE: design/dtw_core.sv
`default_nettype none

module dtw_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire dtw_pkg::in_item_t item,
    output dtw_pkg::out_item_t     result
);
    import dtw_pkg::*;

    typedef struct packed {
        logic req;
        logic wake;
        logic pulse_int;
        logic pulse_wake;
    } chk_t;

    logic [TimerOneWidth-1:0] t1_reg, t1_next;
    logic [TimerTwoWidth-1:0] t2_reg, t2_next;
    logic wake1_reg, wake1_next, int1_reg, int1_next, req1_reg, req1_next;
    logic wake2_reg, wake2_next, int2_reg, int2_next, req2_reg, req2_next;
    logic run_reg, run_next;

    function automatic chk_t check_timer(input logic top, input logic wake,
                                         input logic int_en, input logic req,
                                         input logic shut);
        chk_t c;
        c.req        = req;
        c.wake       = wake;
        c.pulse_int  = 1'b0;
        c.pulse_wake = 1'b0;
        if (!top) begin
            c.req = 1'b0;
        end else begin
            if (wake || int_en) c.req = 1'b1;
            if ((!shut || wake) && int_en) c.pulse_int = 1'b1;
            if (shut && wake) begin
                c.wake       = 1'b0;
                c.pulse_wake = 1'b1;
            end
        end
        return c;
    endfunction

    always_comb begin
        logic [TimerOneWidth-1:0] v1;
        logic [TimerTwoWidth-1:0] v2;
        logic                     hold_ok;
        logic                     shut;
        chk_t                     c1, c2;
        logic [TimerTwoWidth-1:0] rd;
        logic                     p_int, p_wake;

        shut = item.cpu_shutdown;
        // hold condition on timer two except for its top bit
        hold_ok = item.interrupts_enabled && (!shut || wake2_reg) && int2_reg;

        t1_next    = t1_reg;
        t2_next    = t2_reg;
        wake1_next = wake1_reg;
        int1_next  = int1_reg;
        req1_next  = req1_reg;
        wake2_next = wake2_reg;
        int2_next  = int2_reg;
        req2_next  = req2_reg;
        run_next   = run_reg;
        rd         = '0;
        p_int      = 1'b0;
        p_wake     = 1'b0;

        v1 = t1_reg;
        v2 = t2_reg;

        case (req_type_t'(item.req_type))
            REQ_T1_TICK, REQ_RD_T1, REQ_WR_T1: begin
                v1 = (item.req_type == REQ_T1_TICK) ? t1_reg - 1'b1 :
                     (item.req_type == REQ_WR_T1) ? item.write_data[TimerOneWidth-1:0] :
                     t1_reg;
            end
            REQ_T2_TICK: begin
                v2 = t2_reg - 1'b1;
                if (hold_ok && v2[TimerTwoWidth-1]) v2 = ALL_ONES;
            end
            REQ_RD_T2: begin
                if (run_reg && hold_ok && v2[TimerTwoWidth-1]) v2 = ALL_ONES;
            end
            REQ_WR_T2: begin
                v2 = item.write_data;
            end
            default: begin
            end
        endcase

        c1 = check_timer(v1[TimerOneWidth-1], wake1_reg, int1_reg, req1_reg, shut);
        c2 = check_timer(v2[TimerTwoWidth-1], wake2_reg, int2_reg, req2_reg, shut);

        case (req_type_t'(item.req_type))
            REQ_T1_TICK: begin
                if (run_reg) begin
                    t1_next = v1; req1_next = c1.req; wake1_next = c1.wake;
                    p_int = c1.pulse_int; p_wake = c1.pulse_wake;
                end
            end
            REQ_T2_TICK: begin
                if (run_reg) begin
                    t2_next = v2; req2_next = c2.req; wake2_next = c2.wake;
                    p_int = c2.pulse_int; p_wake = c2.pulse_wake;
                end
            end
            REQ_RD_T1: begin
                rd = {{(TimerTwoWidth-TimerOneWidth){1'b0}}, t1_reg};
                req1_next = c1.req; wake1_next = c1.wake;
                p_int = c1.pulse_int; p_wake = c1.pulse_wake;
            end
            REQ_RD_T2: begin
                rd = v2;
                t2_next = v2; req2_next = c2.req; wake2_next = c2.wake;
                p_int = c2.pulse_int; p_wake = c2.pulse_wake;
            end
            REQ_WR_T1: begin
                // same value write leaves everything alone
                if (v1 != t1_reg) begin
                    t1_next = v1; req1_next = c1.req; wake1_next = c1.wake;
                    p_int = c1.pulse_int; p_wake = c1.pulse_wake;
                end
            end
            REQ_WR_T2: begin
                t2_next = v2; req2_next = c2.req; wake2_next = c2.wake;
                p_int = c2.pulse_int; p_wake = c2.pulse_wake;
            end
            REQ_CTL_T1: begin
                wake1_next = item.ctl_wake;
                int1_next  = item.ctl_int;
            end
            REQ_CTL_T2: begin
                wake2_next = item.ctl_wake;
                int2_next  = item.ctl_int;
                run_next   = item.ctl_run;
            end
            default: begin
            end
        endcase

        result.read_data       = rd;
        result.t1_request      = req1_next;
        result.t2_request      = req2_next;
        result.t1_wake_state   = wake1_next;
        result.t2_wake_state   = wake2_next;
        result.interrupt_pulse = p_int;
        result.wake_pulse      = p_wake;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg    <= '0;
            t2_reg    <= '0;
            wake1_reg <= 1'b0;
            int1_reg  <= 1'b0;
            req1_reg  <= 1'b0;
            wake2_reg <= 1'b0;
            int2_reg  <= 1'b0;
            req2_reg  <= 1'b0;
            run_reg   <= 1'b0;
        end else if (step_en) begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            wake1_reg <= wake1_next;
            int1_reg  <= int1_next;
            req1_reg  <= req1_next;
            wake2_reg <= wake2_next;
            int2_reg  <= int2_next;
            req2_reg  <= req2_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dual_timer_with_wake_and_irq.sv
// Dual down-counting timer block: 4-bit timer one and 32-bit timer two,
// each with wake, interrupt and service request bits.
// Input channel s_valid/s_ready/s_data carries one request per transaction
// (tick, read, write or control write of either timer). The result channel
// m_valid/m_ready/m_data returns exactly one result per request, in order.
// A request accepted into the input register moves on into the result
// register, which drives m_data, once that register is free.
// Throughput: one request per cycle while m_ready stays high; the timer state is updated in the
// same cycle the request moves from the input register to the result
// register, so back-to-back requests see each other's effects.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; after that s_ready drops until
// m_ready returns.
// Reset (aresetn low, synchronous) clears both timers, all control and
// request bits, the run bit and both valid flags.
`default_nettype none

module dual_timer_with_wake_and_irq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dtw_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dtw_pkg::out_item_t      m_data
);
    import dtw_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance;

    // request moves into the result register when that slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dtw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_item_reg <= s_data;
        if (advance) out_item_reg <= core_result;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

`default_nettype wire

FILE: tb/sv/dual_timer_with_wake_and_irq_tb.sv
`timescale 1ns / 1ps

module dual_timer_with_wake_and_irq_tb;
    import dtw_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int RandomCount = 500;
    localparam int CalmTail    = 60;
    localparam int LongStall   = 250;

    typedef struct packed {
        in_item_t item;
        logic     drain_first;
    } planned_req_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    dual_timer_with_wake_and_irq i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    planned_req_t request_plan[$];
    out_item_t    timer_results_q[$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  accepted     = 0;
    int  results_seen = 0;
    int  irq_seen     = 0;
    int  wakes_seen   = 0;
    int  req_seen[8];
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  stall_left   = 0;
    logic calm        = 1'b0;

    // predicted timer state
    logic [TimerOneWidth-1:0] t1_count;
    logic [TimerTwoWidth-1:0] t2_count;
    logic t1_wake, t1_inten, t1_req;
    logic t2_wake, t2_inten, t2_req;
    logic run_bit;
    logic irq_flag, wake_flag;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // top bit check: returns the new {wake, request}, raises the pulse flags
    function automatic logic [1:0] service(input logic top, input logic wake,
                                           input logic inten, input logic req,
                                           input logic shut);
        logic w;
        logic r;
        w = wake;
        r = req;
        if (!top) begin
            return {w, 1'b0};
        end
        if (wake || inten) begin
            r = 1'b1;
        end
        if ((!shut || wake) && inten) begin
            irq_flag = 1'b1;
        end
        if (shut && wake) begin
            w = 1'b0;
            wake_flag = 1'b1;
        end
        return {w, r};
    endfunction

    function automatic void hold_t2(input logic shut, input logic inte);
        if (inte && t2_count[TimerTwoWidth-1] && (!shut || t2_wake) && t2_inten) begin
            t2_count = ALL_ONES;
        end
    endfunction

    function automatic out_item_t timer_step(input in_item_t t);
        out_item_t                res;
        logic [TimerTwoWidth-1:0] rd;
        logic [TimerOneWidth-1:0] v;
        rd = '0;
        irq_flag = 1'b0;
        wake_flag = 1'b0;
        case (req_type_t'(t.req_type))
            REQ_T1_TICK: begin
                if (run_bit) begin
                    t1_count = t1_count - 1'b1;
                    {t1_wake, t1_req} = service(t1_count[TimerOneWidth-1], t1_wake,
                                                t1_inten, t1_req, t.cpu_shutdown);
                end
            end
            REQ_T2_TICK: begin
                if (run_bit) begin
                    t2_count = t2_count - 1'b1;
                    hold_t2(t.cpu_shutdown, t.interrupts_enabled);
                    {t2_wake, t2_req} = service(t2_count[TimerTwoWidth-1], t2_wake,
                                                t2_inten, t2_req, t.cpu_shutdown);
                end
            end
            REQ_RD_T1: begin
                rd = {{(TimerTwoWidth-TimerOneWidth){1'b0}}, t1_count};
                {t1_wake, t1_req} = service(t1_count[TimerOneWidth-1], t1_wake,
                                            t1_inten, t1_req, t.cpu_shutdown);
            end
            REQ_RD_T2: begin
                if (run_bit) begin
                    hold_t2(t.cpu_shutdown, t.interrupts_enabled);
                end
                rd = t2_count;
                {t2_wake, t2_req} = service(t2_count[TimerTwoWidth-1], t2_wake,
                                            t2_inten, t2_req, t.cpu_shutdown);
            end
            REQ_WR_T1: begin
                v = t.write_data[TimerOneWidth-1:0];
                // same value write leaves everything alone
                if (v != t1_count) begin
                    t1_count = v;
                    {t1_wake, t1_req} = service(t1_count[TimerOneWidth-1], t1_wake,
                                                t1_inten, t1_req, t.cpu_shutdown);
                end
            end
            REQ_WR_T2: begin
                t2_count = t.write_data;
                {t2_wake, t2_req} = service(t2_count[TimerTwoWidth-1], t2_wake,
                                            t2_inten, t2_req, t.cpu_shutdown);
            end
            REQ_CTL_T1: begin
                t1_wake = t.ctl_wake;
                t1_inten = t.ctl_int;
            end
            default: begin
                t2_wake = t.ctl_wake;
                t2_inten = t.ctl_int;
                run_bit = t.ctl_run;
            end
        endcase
        res.read_data = rd;
        res.t1_request = t1_req;
        res.t2_request = t2_req;
        res.t1_wake_state = t1_wake;
        res.t2_wake_state = t2_wake;
        res.interrupt_pulse = irq_flag;
        res.wake_pulse = wake_flag;
        return res;
    endfunction

    task automatic queue_item(input req_type_t rt, input logic [TimerTwoWidth-1:0] d,
                              input logic w, input logic i, input logic r,
                              input logic sh, input logic ie, input logic drain);
        planned_req_t p;
        p.item.req_type = rt;
        p.item.write_data = d;
        p.item.ctl_wake = w;
        p.item.ctl_int = i;
        p.item.ctl_run = r;
        p.item.cpu_shutdown = sh;
        p.item.interrupts_enabled = ie;
        p.drain_first = drain;
        request_plan.push_back(p);
    endtask

    task automatic report_field(input string name, input logic [TimerTwoWidth-1:0] want,
                                input logic [TimerTwoWidth-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver: presents the head of the plan, holds it until the transaction
    always @(posedge aclk) begin : drive_proc
        logic     offer;
        in_item_t offer_data;
        logic     idle_ok;
        offer = s_valid;
        offer_data = s_data;
        if (!aresetn) begin
            offer = 1'b0;
            offer_data = '0;
        end else begin
            if (s_valid && s_ready) begin
                timer_results_q.push_back(timer_step(s_data));
                req_seen[s_data.req_type]++;
                accepted++;
                void'(request_plan.pop_front());
                offer = 1'b0;
            end
            calm = (request_plan.size() < CalmTail);
            idle_ok = !calm && ((accepted / 40) % 4 != 3);
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_plan.size() != 0) begin
                    if (!(request_plan[0].drain_first && timer_results_q.size() != 0)) begin
                        if (idle_ok && $urandom_range(0, 3) == 0) begin
                            send_gap = $urandom_range(0, 5);
                        end else begin
                            offer = 1'b1;
                            offer_data = request_plan[0].item;
                        end
                    end
                end
            end
        end
        s_valid <= offer;
        s_data <= offer_data;
    end

    // monitor: checks each result transaction and drives m_ready
    always @(posedge aclk) begin : monitor_proc
        logic      rdy;
        out_item_t want;
        if (!aresetn) begin
            rdy = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.interrupt_pulse) irq_seen++;
                if (m_data.wake_pulse) wakes_seen++;
                if (timer_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = timer_results_q.pop_front();
                    report_field("read_data", want.read_data, m_data.read_data);
                    report_field("t1_request", 32'(want.t1_request),
                                 32'(m_data.t1_request));
                    report_field("t2_request", 32'(want.t2_request),
                                 32'(m_data.t2_request));
                    report_field("t1_wake_state", 32'(want.t1_wake_state),
                                 32'(m_data.t1_wake_state));
                    report_field("t2_wake_state", 32'(want.t2_wake_state),
                                 32'(m_data.t2_wake_state));
                    report_field("interrupt_pulse", 32'(want.interrupt_pulse),
                                 32'(m_data.interrupt_pulse));
                    report_field("wake_pulse", 32'(want.wake_pulse),
                                 32'(m_data.wake_pulse));
                end
                // one long hold-off so the block backs up into s_ready
                if (results_seen == 120) stall_left = LongStall;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else if (!calm && ((results_seen / 40) % 4 != 2) &&
                         $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(0, 5);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin : watchdog_proc
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d requests left, %0d results outstanding",
                     cycle_count, request_plan.size(), timer_results_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus_proc
        int                       pick;
        req_type_t                rt;
        logic [TimerTwoWidth-1:0] d;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        t1_count = '0;
        t2_count = '0;
        t1_wake = 1'b0;
        t1_inten = 1'b0;
        t1_req = 1'b0;
        t2_wake = 1'b0;
        t2_inten = 1'b0;
        t2_req = 1'b0;
        run_bit = 1'b0;
        for (int k = 0; k < 8; k++) req_seen[k] = 0;

        // directed: reset values, stopped ticks, top bit cases, hold, shutdown wake
        queue_item(REQ_RD_T1, 32'h0, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_RD_T2, 32'h0, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_T1_TICK, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_T2_TICK, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_CTL_T1, 32'h0, 1, 1, 0, 0, 0, 0);
        queue_item(REQ_CTL_T2, 32'h0, 1, 1, 1, 0, 0, 0);
        queue_item(REQ_WR_T1, 32'h8, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_WR_T1, 32'h8, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_WR_T1, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 0);
        queue_item(REQ_WR_T1, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_T1_TICK, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_T1_TICK, 32'h0, 0, 0, 0, 1, 1, 0);
        queue_item(REQ_WR_T2, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_T2_TICK, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_WR_T2, 32'h8000_0001, 0, 0, 0, 1, 0, 0);
        queue_item(REQ_RD_T2, 32'h0, 0, 0, 0, 1, 1, 0);
        queue_item(REQ_RD_T2, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_WR_T2, ALL_ONES, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_WR_T2, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_CTL_T1, 32'h0, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_WR_T1, 32'h9, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_CTL_T2, 32'h0, 0, 0, 0, 0, 0, 0);
        queue_item(REQ_T2_TICK, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_RD_T2, 32'h0, 0, 0, 0, 0, 1, 0);
        queue_item(REQ_CTL_T2, 32'h0, 1, 0, 1, 0, 0, 1);

        // random: mostly running timers with values near the top-bit boundaries
        for (int n = 0; n < RandomCount; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) rt = REQ_T1_TICK;
            else if (pick < 44) rt = REQ_T2_TICK;
            else if (pick < 52) rt = REQ_RD_T1;
            else if (pick < 60) rt = REQ_RD_T2;
            else if (pick < 70) rt = REQ_WR_T1;
            else if (pick < 82) rt = REQ_WR_T2;
            else if (pick < 90) rt = REQ_CTL_T1;
            else rt = REQ_CTL_T2;
            d = $urandom();
            if (rt == REQ_WR_T2) begin
                case ($urandom_range(0, 4))
                    0: d = 32'h8000_0000 + $urandom_range(0, 3);
                    1: d = 32'h7FFF_FFFF - $urandom_range(0, 2);
                    2: d = $urandom_range(0, 3);
                    3: d = ALL_ONES;
                    default: ;
                endcase
            end
            queue_item(rt, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0,
                       $urandom_range(0, 9) != 0, n == 260 || n == 400);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_plan.size() != 0 || timer_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d control writes",
                 accepted, req_seen[REQ_T1_TICK] + req_seen[REQ_T2_TICK],
                 req_seen[REQ_RD_T1] + req_seen[REQ_RD_T2],
                 req_seen[REQ_WR_T1] + req_seen[REQ_WR_T2],
                 req_seen[REQ_CTL_T1] + req_seen[REQ_CTL_T2]);
        $display("%0d results checked, %0d interrupt pulses, %0d wake pulses, %0d mismatches",
                 results_seen, irq_seen, wakes_seen, mismatches);
        if (mismatches == 0 && timer_results_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
